FILE: sv/i2cm_pkg.sv
// i2cm_pkg: shared types and constants of the i2c master byte engine
// no dependencies; imported by the top, i2cm_wait_timer and i2cm_ctrl

package i2cm_pkg;

  // command codes carried in the input item
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // reset value of the half period register
  localparam logic [15:0] HALF_PERIOD_RST = 16'd500;

  // last data bit index within a byte, ack slot follows it
  localparam logic [3:0] LAST_DATA_BIT = 4'd7;
  localparam logic [3:0] ACK_BIT       = 4'd8;

  // bus phase sequencer states
  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_ST_HI = 5'd1,
    PH_ST_D1 = 5'd2,
    PH_ST_D2 = 5'd3,
    PH_SP_D1 = 5'd4,
    PH_SP_HI = 5'd5,
    PH_SP_D2 = 5'd6,
    PH_SP_D3 = 5'd7,
    PH_WR_D1 = 5'd8,
    PH_WR_HI = 5'd9,
    PH_WR_D2 = 5'd10,
    PH_RD_D1 = 5'd11,
    PH_RD_HI = 5'd12,
    PH_RD_D2 = 5'd13
  } i2cm_phase_t;

  // sequencer to half period timer
  typedef struct packed {
    logic load;  // restart the half period wait
    logic step;  // one tick spent in a waiting phase
  } i2cm_wait_ctrl_t;

  // result of one tick
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       slave_ack;
    logic       done_res;
    logic       busy_res;
    logic       sda_pull_low;
    logic       scl_pull_low;
  } i2cm_result_t;

  // sda pull for bit slot bit_idx of a byte command
  function automatic logic drive_bit(input logic       writing,
                                     input logic [3:0] bit_idx,
                                     input logic [7:0] data,
                                     input logic       ack);
    logic [2:0] sel;
    logic       res;
    sel = 3'(LAST_DATA_BIT - bit_idx);
    if (writing) begin
      res = (bit_idx < ACK_BIT) ? ~data[sel] : 1'b0;
    end else begin
      res = (bit_idx < ACK_BIT) ? 1'b0 : ack;
    end
    return res;
  endfunction

endpackage

FILE: sv/i2c_master_byte_engine_top.sv
// i2c_master_byte_engine_top: open-drain i2c master byte engine, top level
// depends on i2cm_pkg, i2cm_wait_timer and i2cm_ctrl
//
// Usage
//   in_*  : one item per bus timing tick, carrying the sampled scl and sda
//           levels and, while the engine is idle, a command (start, stop,
//           write byte, read byte with ack or nak). Commands seen while busy
//           or on the done tick are ignored.
//   out_* : exactly one result item per input item: the line pulls, busy,
//           a one-item done pulse, the slave ack of the last write and the
//           byte of the last read.
//   cfg_* : writes the half period in ticks; write only while idle.
// Latency and throughput
//   one item per clock cycle unless stalled; each result appears in the
//   cycle after acceptance, from the output register. The next state is
//   computed in one pass from the state registers and the accepted item.
// Reset and stall
//   rst_n (synchronous) releases both lines, returns to idle, clears the
//   held ack and byte and sets the half period to 500 ticks.
//   When out_tready is low a valid result is held and in_tready drops, so no
//   tick is taken until the result is consumed; bus timing counts items.

module i2c_master_byte_engine_top import i2cm_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // command, tx_byte[10:3], send_ack[11], scl_line[12], sda_line[13], zeros
  input  logic [15:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // scl_pull_low, sda_pull_low[1], busy_res[2], done_res[3], slave_ack[4],
  // rx_byte[12:5], zeros
  output logic [15:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);

  logic            acc;
  logic [15:0]     half_period_r;
  i2cm_wait_ctrl_t wait_ctrl;
  logic            wait_over;
  i2cm_result_t    result;
  logic            out_tvalid_r;
  logic [15:0]     out_tdata_r;

  assign acc       = in_tvalid && in_tready;
  assign in_tready = !out_tvalid_r || out_tready;
  assign cfg_ready = 1'b1;

  // half period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      half_period_r <= cfg_data;
    end
  end

  i2cm_wait_timer #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_timer (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (wait_ctrl),
    .half_period (half_period_r),
    .over        (wait_over)
  );

  i2cm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .command   (in_tdata[2:0]),
    .tx_byte   (in_tdata[10:3]),
    .send_ack  (in_tdata[11]),
    .scl_line  (in_tdata[12]),
    .sda_line  (in_tdata[13]),
    .wait_over (wait_over),
    .wait_ctrl (wait_ctrl),
    .result    (result)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (acc) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (acc) begin
      out_tdata_r <= {3'd0, result};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: sv/i2cm_wait_timer.sv
// i2cm_wait_timer: half period down counter with counter range saturation
// depends on i2cm_pkg for the control struct

module i2cm_wait_timer import i2cm_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  i2cm_wait_ctrl_t ctrl,
  input  logic [15:0]     half_period,
  output logic            over
);

  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  logic [COUNT_WIDTH-1:0] wait_count_r;
  logic [COUNT_WIDTH-1:0] wait_count_nxt;
  logic [15:0]            half_nz;
  logic [32:0]            half_ext;
  logic [COUNT_WIDTH-1:0] load_val;

  // zero acts as one tick, saturate to the counter range
  always_comb begin
    half_nz  = (half_period == 16'd0) ? 16'd1 : half_period;
    half_ext = {17'd0, half_nz};
    load_val = (half_ext > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0]
                                    : half_ext[COUNT_WIDTH-1:0];
  end

  // wait ends on the tick the count is one or less
  assign over = (wait_count_r[COUNT_WIDTH-1:1] == '0);

  // next count
  always_comb begin
    wait_count_nxt = wait_count_r;
    if (ctrl.load) begin
      wait_count_nxt = load_val;
    end else if (ctrl.step) begin
      wait_count_nxt = over ? '0 : wait_count_r - COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_count_r <= '0;
    end else begin
      wait_count_r <= wait_count_nxt;
    end
  end

endmodule

FILE: sv/i2cm_ctrl.sv
// i2cm_ctrl: bus phase sequencer, bit shifter and line drivers
// depends on i2cm_pkg; pairs with i2cm_wait_timer for the half period waits

module i2cm_ctrl import i2cm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [2:0]      command,
  input  logic [7:0]      tx_byte,
  input  logic            send_ack,
  input  logic            scl_line,
  input  logic            sda_line,
  input  logic            wait_over,
  output i2cm_wait_ctrl_t wait_ctrl,
  output i2cm_result_t    result
);

  i2cm_phase_t phase_r, phase_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic        ack_to_send_r, ack_to_send_nxt;
  logic        scl_drive_r, scl_drive_nxt;
  logic        sda_drive_r, sda_drive_nxt;
  logic        ack_seen_r, ack_seen_nxt;
  logic [7:0]  rx_byte_r, rx_byte_nxt;
  logic        done;
  logic        writing;
  logic [3:0]  bit_inc;
  logic [7:0]  shift_in;

  assign writing  = (phase_r == PH_WR_D2);
  assign bit_inc  = bit_count_r + 4'd1;
  assign shift_in = {shift_byte_r[6:0], sda_line};

  // next state and outputs, state moves only on an accepted item
  always_comb begin
    phase_nxt       = phase_r;
    bit_count_nxt   = bit_count_r;
    shift_byte_nxt  = shift_byte_r;
    ack_to_send_nxt = ack_to_send_r;
    scl_drive_nxt   = scl_drive_r;
    sda_drive_nxt   = sda_drive_r;
    ack_seen_nxt    = ack_seen_r;
    rx_byte_nxt     = rx_byte_r;
    done            = 1'b0;
    wait_ctrl.load  = 1'b0;
    wait_ctrl.step  = 1'b0;
    if (acc) begin
      case (phase_r)
        PH_IDLE: begin
          case (command)
            CMD_START: begin
              sda_drive_nxt = 1'b0;
              scl_drive_nxt = 1'b0;
              phase_nxt     = PH_ST_HI;
            end
            CMD_STOP: begin
              sda_drive_nxt  = 1'b1;
              wait_ctrl.load = 1'b1;
              phase_nxt      = PH_SP_D1;
            end
            CMD_WRITE: begin
              shift_byte_nxt = tx_byte;
              bit_count_nxt  = 4'd0;
              sda_drive_nxt  = drive_bit(1'b1, 4'd0, tx_byte, ack_to_send_r);
              wait_ctrl.load = 1'b1;
              phase_nxt      = PH_WR_D1;
            end
            CMD_READ: begin
              ack_to_send_nxt = send_ack;
              shift_byte_nxt  = 8'd0;
              bit_count_nxt   = 4'd0;
              sda_drive_nxt   = drive_bit(1'b0, 4'd0, 8'd0, send_ack);
              wait_ctrl.load  = 1'b1;
              phase_nxt       = PH_RD_D1;
            end
            default: begin
            end
          endcase
        end
        // waits for scl released high (clock stretching)
        PH_ST_HI, PH_SP_HI, PH_WR_HI, PH_RD_HI: begin
          if (scl_line) begin
            wait_ctrl.load = 1'b1;
            case (phase_r)
              PH_ST_HI: phase_nxt = PH_ST_D1;
              PH_SP_HI: phase_nxt = PH_SP_D2;
              PH_WR_HI: phase_nxt = PH_WR_D2;
              default:  phase_nxt = PH_RD_D2;
            endcase
          end
        end
        PH_ST_D1: begin
          wait_ctrl.step = 1'b1;
          if (wait_over) begin
            sda_drive_nxt  = 1'b1;
            wait_ctrl.load = 1'b1;
            phase_nxt      = PH_ST_D2;
          end
        end
        PH_ST_D2: begin
          wait_ctrl.step = 1'b1;
          if (wait_over) begin
            scl_drive_nxt = 1'b1;
            phase_nxt     = PH_IDLE;
            done          = 1'b1;
          end
        end
        PH_SP_D1: begin
          wait_ctrl.step = 1'b1;
          if (wait_over) begin
            scl_drive_nxt = 1'b0;
            phase_nxt     = PH_SP_HI;
          end
        end
        PH_SP_D2: begin
          wait_ctrl.step = 1'b1;
          if (wait_over) begin
            sda_drive_nxt  = 1'b0;
            wait_ctrl.load = 1'b1;
            phase_nxt      = PH_SP_D3;
          end
        end
        PH_SP_D3: begin
          wait_ctrl.step = 1'b1;
          if (wait_over) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        end
        // release scl after the data setup half period
        PH_WR_D1, PH_RD_D1: begin
          wait_ctrl.step = 1'b1;
          if (wait_over) begin
            scl_drive_nxt = 1'b0;
            phase_nxt     = (phase_r == PH_WR_D1) ? PH_WR_HI : PH_RD_HI;
          end
        end
        // sample at the end of scl high, then pull scl low
        PH_WR_D2, PH_RD_D2: begin
          wait_ctrl.step = 1'b1;
          if (wait_over) begin
            if (writing) begin
              if (bit_count_r >= ACK_BIT) begin
                ack_seen_nxt = ~sda_line;
              end
            end else if (bit_count_r < ACK_BIT) begin
              shift_byte_nxt = shift_in;
              if (bit_count_r == LAST_DATA_BIT) begin
                rx_byte_nxt = shift_in;
              end
            end
            scl_drive_nxt = 1'b1;
            bit_count_nxt = bit_inc;
            if (bit_inc > ACK_BIT) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              sda_drive_nxt  = drive_bit(writing, bit_inc, shift_byte_r, ack_to_send_r);
              wait_ctrl.load = 1'b1;
              phase_nxt      = writing ? PH_WR_D1 : PH_RD_D1;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bit_count_r   <= 4'd0;
      shift_byte_r  <= 8'd0;
      ack_to_send_r <= 1'b0;
      scl_drive_r   <= 1'b0;
      sda_drive_r   <= 1'b0;
      ack_seen_r    <= 1'b0;
      rx_byte_r     <= 8'd0;
    end else begin
      phase_r       <= phase_nxt;
      bit_count_r   <= bit_count_nxt;
      shift_byte_r  <= shift_byte_nxt;
      ack_to_send_r <= ack_to_send_nxt;
      scl_drive_r   <= scl_drive_nxt;
      sda_drive_r   <= sda_drive_nxt;
      ack_seen_r    <= ack_seen_nxt;
      rx_byte_r     <= rx_byte_nxt;
    end
  end

  // post update values of this tick
  always_comb begin
    result.scl_pull_low = scl_drive_nxt;
    result.sda_pull_low = sda_drive_nxt;
    result.busy_res     = (phase_nxt != PH_IDLE);
    result.done_res     = done;
    result.slave_ack    = ack_seen_nxt;
    result.rx_byte      = rx_byte_nxt;
  end

endmodule

FILE: sv/i2cm_checker.sv
// i2cm_checker: port level checks of the i2c master byte engine
// depends on i2c_master_byte_engine_top, attached to it by bind

module i2cm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);

  // an accepted item always yields a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item produced no result");

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // done is reported only with busy cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2])
    else $error("done while busy");

  // no input taken while an unconsumed result blocks the output
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("item accepted over a stalled result");

  // nothing pending right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (.*);
